// ----- design/greedy_point_suppression_core_assert.svh -----
// Assertion macros shared by the point suppression RTL.
// Expects signals named clock and reset in the including module.
`ifndef GREEDY_POINT_SUPPRESSION_CORE_ASSERT_SVH
`define GREEDY_POINT_SUPPRESSION_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GPSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define GPSC_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define GPSC_ASSERT(lbl, prop, msg)
`define GPSC_NEVER(lbl, expr, msg)
`endif
`endif

// ----- design/gps_pkg.sv -----
// Package for the greedy point suppression core: sizes, payload types and helpers.
// Has no dependencies; every module of the core imports it.
package gps_pkg;

   localparam int MAX_KEPT    = 64;
   localparam int COORD_BITS  = 12;
   localparam int FIELD_W     = 12;
   localparam int STR_W       = 8;
   localparam int LIMIT_W     = 26;
   localparam int SQ_W        = 2 * COORD_BITS;
   localparam int SUM_W       = SQ_W + 1;
   localparam int CMP_W       = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
   localparam int IDX_W       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W       = $clog2(MAX_KEPT + 1);
   localparam int DIST_DRAIN  = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(6400);
   localparam logic REG_RADIUS_SQ_LIMIT = 1'b0;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   typedef struct packed {
      logic              shift;
      logic              load;
      point_type         pt;
   } cell_ctrl_type;

   typedef struct packed {
      logic [FIELD_W-1:0] point_x;
      logic [FIELD_W-1:0] point_y;
      logic [STR_W-1:0]   strength;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] kept_x;
      logic [FIELD_W-1:0] kept_y;
      logic [STR_W-1:0]   kept_strength;
      logic               list_overflow;
   } rsp_type;

   function automatic coord_type to_coord(input logic [FIELD_W-1:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[COORD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input coord_type c);
      logic [31:0] t;
      t = 32'(c);
      return t[FIELD_W-1:0];
   endfunction

endpackage

// ----- design/gps_cell.sv -----
// One cell of the kept-point ring: holds one point and passes it to its neighbor.
// Depends on gps_pkg.
module gps_cell
   import gps_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  point_type     from_next,
   output point_type     pt
);

   point_type pt_ff;
   point_type pt_in;

   always_comb begin
      priority if (ctrl.load) begin
         pt_in = ctrl.pt;
      end else if (ctrl.shift) begin
         pt_in = from_next;
      end else begin
         pt_in = pt_ff;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt = pt_ff;

endmodule

// ----- design/gps_dist.sv -----
// Pipelined squared-distance unit that compares the candidate with one kept point
// per cycle and accumulates a suppression hit. Depends on gps_pkg.
module gps_dist
   import gps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               sample_valid,
   input  point_type          head,
   input  point_type          cand,
   input  logic [LIMIT_W-1:0] limit,
   output logic               hit
);

   coord_type         dx_ff, dx_in, dy_ff, dy_in;
   logic              v1_ff, v2_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [SUM_W-1:0]  sum;
   logic              near;
   logic              hit_ff, hit_in;

   always_comb begin
      dx_in = (cand.x >= head.x) ? cand.x - head.x : head.x - cand.x;
      dy_in = (cand.y >= head.y) ? cand.y - head.y : head.y - cand.y;
      sum   = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      near  = CMP_W'(sum) < CMP_W'(limit);
      priority if (clear) begin
         hit_in = 1'b0;
      end else if (v2_ff && near) begin
         hit_in = 1'b1;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v1_ff  <= sample_valid;
         v2_ff  <= v1_ff;
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ----- design/greedy_point_suppression_core.sv -----
// Greedy radius suppression of corner points. Every item is rotated past all
// MAX_KEPT kept points held in a ring of cells, one point per cycle into a
// three-stage squared-distance unit; the next item is taken only once the scan, the
// drain and the finish of the last one are done. A surviving point is placed in a
// result register, so a new item is accepted while that result still waits; the ring
// rotation sets the rate unless a second survivor must wait in finish for rsp_ready.
module greedy_point_suppression_core
   import gps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "greedy_point_suppression_core_assert.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [1:0]         drain_ff, drain_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   point_type          cand_ff, cand_in;
   logic [STR_W-1:0]   str_ff, str_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               load_en;
   logic               req_take;
   logic               sample_valid;
   logic               hit;
   logic               csr_reg_hit;
   point_type          ring [MAX_KEPT];
   cell_ctrl_type      ctrl [MAX_KEPT];

   assign req_take     = req_valid && (state_ff == ST_IDLE);
   assign req_ready    = (state_ff == ST_IDLE);
   assign sample_valid = (state_ff == ST_SCAN) && (CNT_W'(step_ff) < count_ff);

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_ring
      assign ctrl[i].shift = (state_ff == ST_SCAN);
      assign ctrl[i].load  = load_en && (count_ff == CNT_W'(i));
      assign ctrl[i].pt    = cand_ff;
      gps_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .from_next (ring[(i + 1) % MAX_KEPT]),
         .pt        (ring[i])
      );
   end

   gps_dist u_dist (
      .clock        (clock),
      .reset        (reset),
      .clear        (req_take),
      .sample_valid (sample_valid),
      .head         (ring[0]),
      .cand         (cand_ff),
      .limit        (limit_ff),
      .hit          (hit)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      drain_in     = drain_ff;
      count_in     = count_ff;
      cand_in      = cand_ff;
      str_in       = str_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      load_en      = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cand_in.x = to_coord(req_data.point_x);
               cand_in.y = to_coord(req_data.point_y);
               str_in    = req_data.strength;
               step_in   = '0;
               if (req_data.frame_start) begin
                  count_in = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(MAX_KEPT - 1)) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'(DIST_DRAIN - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (hit) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kept_x        = to_field(cand_ff.x);
               rsp_in.kept_y        = to_field(cand_ff.y);
               rsp_in.kept_strength = str_ff;
               rsp_in.list_overflow = (count_ff == CNT_W'(MAX_KEPT));
               if (count_ff != CNT_W'(MAX_KEPT)) begin
                  load_en  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         drain_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff <= cand_in;
      str_ff  <= str_in;
      rsp_ff  <= rsp_in;
   end

   assign csr_reg_hit = (csr_paddr[CSR_ADDR_W-1:2] == REG_RADIUS_SQ_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_reg_hit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata = csr_reg_hit ? CSR_DATA_W'(limit_ff) : '0;
   assign csr_pready = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `GPSC_NEVER(a_count_bound, count_ff > CNT_W'(MAX_KEPT), "kept count above capacity")
   `GPSC_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH), "result without finish")
   `GPSC_NEVER(a_load_full, load_en && (count_ff == CNT_W'(MAX_KEPT)), "store into full list")
   `GPSC_ASSERT(a_scan_to_drain, (state_ff == ST_DRAIN) && $past(state_ff == ST_SCAN) |-> $past(step_ff == IDX_W'(MAX_KEPT - 1)), "scan ended early")

endmodule

// ----- tb/greedy_point_suppression_core_tb.sv -----
// Self-checking bench for greedy_point_suppression_core: corner point frames go in
// through valid/ready and each kept point that comes out is checked against a predictor.
// Depends on gps_pkg and the core RTL only.
module greedy_point_suppression_core_tb;
   import gps_pkg::*;

   localparam int TIMEOUT_CYCLES = 500000;
   localparam int DRAIN_CYCLES   = 2 * (MAX_KEPT + 4);
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * int'(REG_RADIUS_SQ_LIMIT));

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   req_type            point_queue[$];
   rsp_type            kept_expect[$];
   point_type          kept_pts[MAX_KEPT];
   int                 kept_count;
   logic [LIMIT_W-1:0] radius_limit;

   bit quiet;
   bit req_taken;
   int req_gap;
   int rsp_stall;
   int errors;
   int cycles;
   int points_sent;
   int frames_seen;
   int points_dropped;
   int results_checked;
   int overflow_results;
   int limit_settings;

   greedy_point_suppression_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void suppress_point(input req_type p);
      coord_type        px;
      coord_type        py;
      int unsigned      dx;
      int unsigned      dy;
      longint unsigned  dsq;
      logic             full;
      rsp_type          exp_item;
      px = p.point_x[COORD_BITS-1:0];
      py = p.point_y[COORD_BITS-1:0];
      if (p.frame_start) begin
         kept_count = 0;
         frames_seen++;
      end
      for (int i = 0; i < kept_count; i++) begin
         dx = (px >= kept_pts[i].x) ? px - kept_pts[i].x : kept_pts[i].x - px;
         dy = (py >= kept_pts[i].y) ? py - kept_pts[i].y : kept_pts[i].y - py;
         dsq = longint'(dx) * dx + longint'(dy) * dy;
         if (dsq < longint'(radius_limit)) begin
            points_dropped++;
            return;
         end
      end
      full = (kept_count >= MAX_KEPT);
      if (!full) begin
         kept_pts[kept_count] = '{y: py, x: px};
         kept_count++;
      end
      exp_item.kept_x        = FIELD_W'(px);
      exp_item.kept_y        = FIELD_W'(py);
      exp_item.kept_strength = p.strength;
      exp_item.list_overflow = full;
      kept_expect.insert(kept_expect.size(), exp_item);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            points_sent++;
            suppress_point(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (kept_expect.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual %p", $time, rsp_data);
            end else begin
               want = kept_expect.pop_front();
               results_checked++;
               if (want.list_overflow) overflow_results++;
               check_field("kept_x", want.kept_x, rsp_data.kept_x);
               check_field("kept_y", want.kept_y, rsp_data.kept_y);
               check_field("kept_strength", want.kept_strength, rsp_data.kept_strength);
               check_field("list_overflow", want.list_overflow, rsp_data.list_overflow);
            end
         end
      end
      cycles++;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("%0t: timeout with %0d items still expected", $time, kept_expect.size());
         $display("greedy_point_suppression_core_tb: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (point_queue.size() == 0) begin
         req_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         req_gap = $urandom_range(1, 15) - 1;
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_data <= point_queue.pop_front();
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic add_point(input int x, input int y, input int s, input bit fs);
      req_type item;
      item.point_x     = FIELD_W'(x);
      item.point_y     = FIELD_W'(y);
      item.strength    = STR_W'(s);
      item.frame_start = fs;
      point_queue.insert(point_queue.size(), item);
   endtask

   task automatic add_frames(input int n_items, input int min_len, input int max_len,
                             input int spread);
      int      left;
      int      len;
      int      s;
      int      x;
      int      y;
      int      str;
      req_type base;
      req_type frame_pts[$];
      left = n_items;
      while (left > 0) begin
         len = $urandom_range(min_len, max_len);
         if (len > left) len = left;
         s = 255;
         frame_pts.delete();
         for (int k = 0; k < len; k++) begin
            if (k == 0 || $urandom_range(0, 3) == 0) begin
               x = $urandom_range(0, 4095);
               y = $urandom_range(0, 4095);
            end else begin
               base = frame_pts[$urandom_range(0, frame_pts.size() - 1)];
               x = (int'(base.point_x) + int'($urandom_range(0, 2 * spread)) - spread) & 12'hfff;
               y = (int'(base.point_y) + int'($urandom_range(0, 2 * spread)) - spread) & 12'hfff;
            end
            if ($urandom_range(0, 15) == 0) begin
               str = $urandom_range(0, 255);
            end else begin
               s = s - int'($urandom_range(0, 3));
               if (s < 0) s = 0;
               str = s;
            end
            add_point(x, y, str, k == 0);
            frame_pts.insert(frame_pts.size(), point_queue[$]);
         end
         left -= len;
      end
   endtask

   task automatic wait_idle();
      while (point_queue.size() != 0 || req_valid || kept_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         errors++;
         $display("%0t: radius_sq_limit readback mismatch, expected %0d, actual %0d",
                  $time, value, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      radius_limit = value;
      limit_settings++;
   endtask

   initial begin
      logic [LIMIT_W-1:0] lim;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      quiet        = 1'b0;
      kept_count   = 0;
      radius_limit = LIMIT_RESET;
      limit_settings = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_point(0, 0, 255, 1);
      add_point(79, 0, 250, 0);
      add_point(80, 0, 245, 0);
      add_point(0, 0, 240, 0);
      add_point(4095, 4095, 200, 0);
      add_point(4095, 0, 190, 0);
      add_point(0, 4095, 180, 0);
      add_point(4095, 4095, 170, 0);
      add_point(56, 56, 160, 0);
      add_point(2048, 2048, 255, 0);
      add_point(0, 0, 0, 1);
      add_frames(120, 5, 40, 120);
      wait_idle();

      write_limit(LIMIT_W'(1));
      add_point(100, 100, 255, 1);
      add_point(100, 100, 250, 0);
      add_point(101, 100, 245, 0);
      add_frames(100, 20, 80, 3);
      wait_idle();

      write_limit(LIMIT_W'(0));
      add_point(5, 5, 255, 1);
      add_point(5, 5, 250, 0);
      add_frames(150, 66, 100, 40);
      wait_idle();

      write_limit(LIMIT_W'(33554432));
      add_point(0, 0, 255, 1);
      add_point(4095, 4095, 0, 0);
      add_frames(40, 2, 10, 2000);
      wait_idle();

      repeat (2) begin
         lim = LIMIT_W'($urandom_range(2, 40000));
         write_limit(lim);
         add_frames(90, 5, 70, $rtoi($sqrt(real'(lim))) + 3);
         wait_idle();
      end

      write_limit(LIMIT_RESET);
      quiet = 1'b1;
      add_frames(100, 10, 50, 120);
      wait_idle();

      $display("ran %0d points in %0d frames under %0d radius settings, %0d suppressed",
               points_sent, frames_seen, limit_settings, points_dropped);
      $display("checked %0d kept points, %0d of them flagged as past a full list",
               results_checked, overflow_results);
      if (errors == 0) begin
         $display("greedy_point_suppression_core_tb: done, clean");
      end else begin
         $display("greedy_point_suppression_core_tb: done, errors");
      end
      $finish;
   end

endmodule
